// ----- src/sfc_pkg.sv -----
`default_nettype none

package sfc_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 9;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_TX_MAX_PAYLOAD = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RX_MAX_PAYLOAD = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_END_CODE       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ESC_CODE       = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_END_SUBST      = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_ESC_SUBST      = 3'd5;

    // register reset values
    localparam logic [8:0] RST_MAX_PAYLOAD = 9'd256;
    localparam logic [7:0] RST_END_CODE    = 8'd192;
    localparam logic [7:0] RST_ESC_CODE    = 8'd219;
    localparam logic [7:0] RST_END_SUBST   = 8'd220;
    localparam logic [7:0] RST_ESC_SUBST   = 8'd221;

    // operation codes
    localparam logic OP_ENCODE = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    // result kinds
    localparam logic [1:0] KIND_LINE      = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD   = 2'd1;
    localparam logic [1:0] KIND_FRAME_END = 2'd2;

    localparam int MAX_RESULTS = 3;

    typedef struct packed {
        logic [1:0] out_kind;
        logic [7:0] out_byte;
        logic       last_of_run;
        logic [8:0] frame_length;
        logic       truncated;
    } t_result;

endpackage

`default_nettype wire

// ----- src/slip_frame_codec.sv -----
// slip_frame_codec: SLIP byte-stuffing encoder and decoder sharing one stream.
// Input channel s_axis: tuser selects encode (0) or decode (1), tdata carries
// the byte and the carries_byte flag, tlast closes an encoded frame with END.
// Output channel m_axis: tuser gives the result kind (line byte, payload byte,
// frame end), tlast marks the final result of one input item, tdata holds the
// byte, the received frame length and the truncation flag.
// Configuration: i_cfg_we / i_cfg_index / i_cfg_data write the limits and the
// framing codes; write only while the block is idle.
// Flow: an item is taken into the input register, expands into the three
// entry result buffer once the buffer has drained, and its results are
// then offered from that buffer.
// Each item yields n results (0 to 3); the single output port of the result
// buffer sends them one at a time, so an item that needs escaping holds back
// the next item until its results have drained.
// Reset (synchronous, active low) restores the default codes and limits and
// clears the frame counters, the escape flag and the buffered results.
// When the receiver stalls the current result holds; one more item waits in
// the input register and then s_axis_tready drops.
`default_nettype none

module slip_frame_codec #(
    parameter int MAX_PAYLOAD = 256
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [sfc_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [sfc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [15:0]                     s_axis_tdata,  // data_byte, carries_byte, pad
    input  wire logic                            s_axis_tuser,  // operation
    input  wire logic                            s_axis_tlast,  // last_in_frame
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic [23:0]                          m_axis_tdata,  // out_byte, frame_length,
                                                                // truncated, pad
    output logic [1:0]                           m_axis_tuser,  // out_kind
    output logic                                 m_axis_tlast   // last_of_run
);

    // counts never exceed the 9-bit register range
    localparam logic [8:0] LIMIT_CAP = (MAX_PAYLOAD > 511) ? 9'd511 : 9'(MAX_PAYLOAD);

    // configuration
    logic [8:0] r_tx_max, r_rx_max;
    logic [7:0] r_end_code, r_esc_code, r_end_subst, r_esc_subst;

    // input register
    logic       r_in_valid;
    logic       r_in_op;
    logic [7:0] r_in_byte;
    logic       r_in_carries;
    logic       r_in_last;

    // codec state
    logic [8:0] r_tx_count, n_tx_count;
    logic [8:0] r_rx_count, n_rx_count;
    logic       r_esc_pending, n_esc_pending;
    logic       r_rx_ovf, n_rx_ovf;

    // result buffer
    sfc_pkg::t_result r_res [sfc_pkg::MAX_RESULTS];
    sfc_pkg::t_result n_res [sfc_pkg::MAX_RESULTS];
    logic [1:0] r_cnt, n_cnt;
    logic [1:0] r_idx;

    logic       w_take, w_drain_done, w_load;
    logic [8:0] w_tx_limit, w_rx_limit;
    logic       w_tx_ok;
    logic [7:0] w_dec_byte;
    sfc_pkg::t_result w_cur;

    assign w_tx_limit = (r_tx_max < LIMIT_CAP) ? r_tx_max : LIMIT_CAP;
    assign w_rx_limit = (r_rx_max < LIMIT_CAP) ? r_rx_max : LIMIT_CAP;

    assign w_cur         = r_res[r_idx];
    assign m_axis_tvalid = (r_cnt != 2'd0);
    assign m_axis_tuser  = w_cur.out_kind;
    assign m_axis_tlast  = w_cur.last_of_run;
    assign m_axis_tdata  = {6'd0, w_cur.truncated, w_cur.frame_length, w_cur.out_byte};

    assign w_take       = m_axis_tvalid && m_axis_tready;
    assign w_drain_done = (r_cnt == 2'd0) || (w_take && (r_idx + 2'd1 == r_cnt));
    assign w_load       = r_in_valid && w_drain_done;
    assign s_axis_tready = !r_in_valid || w_load;

    assign w_tx_ok = r_in_carries && (r_tx_count < w_tx_limit);

    // escaped byte mapping, end_subst wins when both substitutes match
    always_comb begin
        w_dec_byte = r_in_byte;
        if (r_esc_pending) begin
            if (r_in_byte == r_end_subst) begin
                w_dec_byte = r_end_code;
            end else if (r_in_byte == r_esc_subst) begin
                w_dec_byte = r_esc_code;
            end
        end
    end

    always_comb begin
        logic [1:0] k;
        k = 2'd0;
        for (int i = 0; i < sfc_pkg::MAX_RESULTS; i++) begin
            n_res[i] = '0;
        end
        n_tx_count    = r_tx_count;
        n_rx_count    = r_rx_count;
        n_esc_pending = r_esc_pending;
        n_rx_ovf      = r_rx_ovf;

        if (r_in_op == sfc_pkg::OP_ENCODE) begin
            if (w_tx_ok) begin
                n_tx_count = r_tx_count + 9'd1;
                if (r_in_byte == r_end_code) begin
                    n_res[0].out_byte = r_esc_code;
                    n_res[1].out_byte = r_end_subst;
                    k = 2'd2;
                end else if (r_in_byte == r_esc_code) begin
                    n_res[0].out_byte = r_esc_code;
                    n_res[1].out_byte = r_esc_subst;
                    k = 2'd2;
                end else begin
                    n_res[0].out_byte = r_in_byte;
                    k = 2'd1;
                end
            end
            if (r_in_last) begin
                n_res[k].out_byte = r_end_code;
                k = k + 2'd1;
                n_tx_count = 9'd0;
            end
            for (int i = 0; i < sfc_pkg::MAX_RESULTS; i++) begin
                n_res[i].out_kind = sfc_pkg::KIND_LINE;
            end
        end else begin
            if (r_in_byte == r_end_code) begin
                n_res[0].out_kind     = sfc_pkg::KIND_FRAME_END;
                n_res[0].frame_length = r_rx_count;
                n_res[0].truncated    = r_rx_ovf;
                k = 2'd1;
                n_rx_count    = 9'd0;
                n_rx_ovf      = 1'b0;
                n_esc_pending = 1'b0;
            end else if (!r_esc_pending && (r_in_byte == r_esc_code)) begin
                n_esc_pending = 1'b1;
            end else begin
                n_esc_pending = 1'b0;
                if (r_rx_count < w_rx_limit) begin
                    n_rx_count        = r_rx_count + 9'd1;
                    n_res[0].out_kind = sfc_pkg::KIND_PAYLOAD;
                    n_res[0].out_byte = w_dec_byte;
                    k = 2'd1;
                end else begin
                    n_rx_ovf = 1'b1;
                end
            end
        end

        if (k != 2'd0) begin
            n_res[k - 2'd1].last_of_run = 1'b1;
        end
        n_cnt = k;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_max    <= sfc_pkg::RST_MAX_PAYLOAD;
            r_rx_max    <= sfc_pkg::RST_MAX_PAYLOAD;
            r_end_code  <= sfc_pkg::RST_END_CODE;
            r_esc_code  <= sfc_pkg::RST_ESC_CODE;
            r_end_subst <= sfc_pkg::RST_END_SUBST;
            r_esc_subst <= sfc_pkg::RST_ESC_SUBST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                sfc_pkg::REG_TX_MAX_PAYLOAD: r_tx_max    <= i_cfg_data;
                sfc_pkg::REG_RX_MAX_PAYLOAD: r_rx_max    <= i_cfg_data;
                sfc_pkg::REG_END_CODE:       r_end_code  <= i_cfg_data[7:0];
                sfc_pkg::REG_ESC_CODE:       r_esc_code  <= i_cfg_data[7:0];
                sfc_pkg::REG_END_SUBST:      r_end_subst <= i_cfg_data[7:0];
                sfc_pkg::REG_ESC_SUBST:      r_esc_subst <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_op      <= s_axis_tuser;
            r_in_byte    <= s_axis_tdata[7:0];
            r_in_carries <= s_axis_tdata[8];
            r_in_last    <= s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_count    <= 9'd0;
            r_rx_count    <= 9'd0;
            r_esc_pending <= 1'b0;
            r_rx_ovf      <= 1'b0;
            r_cnt         <= 2'd0;
            r_idx         <= 2'd0;
        end else if (w_load) begin
            r_tx_count    <= n_tx_count;
            r_rx_count    <= n_rx_count;
            r_esc_pending <= n_esc_pending;
            r_rx_ovf      <= n_rx_ovf;
            r_cnt         <= n_cnt;
            r_idx         <= 2'd0;
        end else if (w_take) begin
            if (w_drain_done) begin
                r_cnt <= 2'd0;
                r_idx <= 2'd0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_res <= n_res;
        end
    end

`ifndef NO_ASSERTIONS
    // the read pointer stays inside the filled part of the buffer
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_idx < r_cnt))
        else $error("result read pointer beyond fill count");

    // a held input item is not overwritten while the buffer drains
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_load) |=> (r_in_valid && $stable(r_in_byte) && $stable(r_in_op)))
        else $error("pending input item lost");

    // a frame end is always the sole result of its item
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == sfc_pkg::KIND_FRAME_END))
            |-> (m_axis_tlast && (r_cnt == 2'd1)))
        else $error("frame end not alone");
`endif

endmodule

`default_nettype wire
